// ----- sv/pfrf_pkg.sv -----
// Shared types, codes and helpers of the page-mode framebuffer fill block.
package pfrf_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int DW          = 8;   // pixels per column byte
  localparam int PGW         = 4;   // page index width (row field reaches page 15)
  localparam logic [DW-1:0] MASK_ALL = 8'hFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;       // capture the input fields
    logic setup;      // build the sweep box from the captured fields
    logic setup_clr;  // build a whole-screen clearing box
    logic step;       // issue one read and advance the walk
    logic rd_issue;   // issue the single-byte read
    logic rd_capture; // latch the read byte as result
    logic out_load;   // move result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;  // fill draws nothing
    logic       last;   // walk sits on its final byte
  } dp_stat_t;

  // Bits of page pg covered by rows [ys, ye).
  function automatic logic [DW-1:0] page_mask(input logic [PGW-1:0] pg,
                                              input logic [5:0] ys,
                                              input logic [6:0] ye);
    logic [7:0] base;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [8:0] hi_bits;
    logic [8:0] lo_bits;
    base = {1'b0, pg, 3'b000};
    lo   = ({2'b00, ys} > base) ? ({2'b00, ys} - base) : 8'd0;
    if ({1'b0, ye} < (base + 8'd8)) begin
      hi = ({1'b0, ye} > base) ? ({1'b0, ye} - base) : 8'd0;
    end else begin
      hi = 8'd8;
    end
    if (lo >= hi) begin
      page_mask = '0;
    end else begin
      hi_bits   = (9'd1 << hi[3:0]) - 9'd1;
      lo_bits   = (9'd1 << lo[3:0]) - 9'd1;
      page_mask = hi_bits[DW-1:0] & ~lo_bits[DW-1:0];
    end
  endfunction

endpackage

// ----- sv/pfrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pfrf_ctrl.sv -----
// Sequencer of the framebuffer block: handshakes and operation phases.
module pfrf_ctrl
  import pfrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   init_q, init_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    unique case (state_q)
      ST_INIT:  state_d = ST_SWEEP;
      ST_IDLE:  if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP: begin
        unique case (stat_i.op)
          OP_CLEAR: state_d = ST_SWEEP;
          OP_FILL:  state_d = stat_i.empty ? ST_DONE : ST_SWEEP;
          OP_READ:  state_d = ST_READ;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_SWEEP: if (stat_i.last) state_d = ST_DRAIN;
      ST_DRAIN: begin
        state_d = init_q ? ST_IDLE : ST_DONE;
        init_d  = 1'b0;
      end
      ST_READ:  state_d = ST_RWAIT;
      ST_RWAIT: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_INIT:  cmd_o.setup_clr = 1'b1;
      ST_IDLE:  cmd_o.load      = in_valid_i;
      ST_SETUP: cmd_o.setup     = 1'b1;
      ST_SWEEP: cmd_o.step      = 1'b1;
      ST_READ:  cmd_o.rd_issue  = 1'b1;
      ST_RWAIT: cmd_o.rd_capture = 1'b1;
      ST_DONE: begin
        cmd_o.out_load = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/pfrf_dpath.sv -----
// Datapath: field capture, page/column walk, read-modify-write and result.
module pfrf_dpath
  import pfrf_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctrl_cmd_t     cmd_i,
  output dp_stat_t      stat_o,
  input  logic [1:0]    op_i,
  input  logic [6:0]    x_start_i,
  input  logic [6:0]    x_stop_i,
  input  logic [5:0]    y_start_i,
  input  logic [6:0]    y_stop_i,
  input  logic          fill_white_i,
  input  logic [2:0]    read_page_i,
  input  logic [6:0]    read_column_i,
  output logic [DW-1:0] read_data_o
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int XW    = (CW > 7) ? CW : 7;
  localparam logic [XW-1:0]  COL_LAST  = XW'(COLUMNS - 1);
  localparam logic [PGW-1:0] PAGE_LAST = PGW'(PAGES - 1);

  // captured item
  logic [1:0]     op_q;
  logic [6:0]     xs_q, xe_q;
  logic [5:0]     ys_q;
  logic [6:0]     ye_q;
  logic           white_q;
  logic [2:0]     rp_q;
  logic [6:0]     rc_q;

  // walk box and position
  logic [XW-1:0]  c_lo_q, c_hi_q, col_q;
  logic [PGW-1:0] p_hi_q, page_q;
  logic [AW-1:0]  base_q;
  logic           clear_q;

  // write-back pipe
  logic           wr_pend_q;
  logic [AW-1:0]  wr_addr_q;
  logic [DW-1:0]  mask_q;

  logic [DW-1:0]  res_q;
  logic [DW-1:0]  out_data_q;

  logic [XW-1:0]  xs_x, xe_x, xe_clip;
  logic [PGW-1:0] p_lo, p_top, p_hi;
  logic [6:0]     ye_m1;
  logic           fill_empty;
  logic           col_end;
  logic [AW-1:0]  sweep_addr, rd_addr, raddr;
  logic           rd_ok;
  logic [DW-1:0]  rdata, wdata;

  assign xs_x    = XW'(xs_q);
  assign xe_x    = XW'(xe_q);
  assign xe_clip = (xe_x > COL_LAST) ? COL_LAST : xe_x;
  assign ye_m1   = ye_q - 7'd1;
  assign p_lo    = PGW'(ys_q[5:3]);
  assign p_top   = ye_m1[6:3];
  assign p_hi    = (p_top > PAGE_LAST) ? PAGE_LAST : p_top;

  assign fill_empty = (xs_q > xe_q) || (ye_q <= {1'b0, ys_q}) || (xs_x > COL_LAST) ||
                      (int'(p_lo) >= PAGES);

  assign col_end    = (col_q == c_hi_q);
  assign sweep_addr = AW'(int'(base_q) + int'(col_q));
  assign rd_ok      = (int'(rp_q) < PAGES) && (int'(rc_q) < COLUMNS);
  assign rd_addr    = AW'(int'(rp_q) * COLUMNS + int'(rc_q));
  assign raddr      = cmd_i.rd_issue ? rd_addr : sweep_addr;

  always_comb begin
    if (clear_q) begin
      wdata = '0;
    end else if (white_q) begin
      wdata = rdata | mask_q;
    end else begin
      wdata = rdata & ~mask_q;
    end
  end

  assign stat_o.op    = op_q;
  assign stat_o.empty = fill_empty;
  assign stat_o.last  = col_end && (page_q == p_hi_q);

  pfrf_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.step || cmd_i.rd_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      xs_q    <= x_start_i;
      xe_q    <= x_stop_i;
      ys_q    <= y_start_i;
      ye_q    <= y_stop_i;
      white_q <= fill_white_i;
      rp_q    <= read_page_i;
      rc_q    <= read_column_i;
    end

    if (cmd_i.setup_clr || (cmd_i.setup && op_q == OP_CLEAR)) begin
      c_lo_q <= '0;
      c_hi_q <= COL_LAST;
      col_q  <= '0;
      page_q <= '0;
      p_hi_q <= PAGE_LAST;
      base_q <= '0;
    end else if (cmd_i.setup) begin
      c_lo_q <= xs_x;
      c_hi_q <= xe_clip;
      col_q  <= xs_x;
      page_q <= p_lo;
      p_hi_q <= p_hi;
      base_q <= AW'(int'(p_lo) * COLUMNS);
    end else if (cmd_i.step) begin
      if (col_end) begin
        col_q  <= c_lo_q;
        page_q <= page_q + PGW'(1);
        base_q <= base_q + AW'(COLUMNS);
      end else begin
        col_q  <= col_q + XW'(1);
      end
    end

    if (cmd_i.step) begin
      wr_addr_q <= sweep_addr;
      mask_q    <= clear_q ? MASK_ALL : page_mask(page_q, ys_q, ye_q);
    end

    if (cmd_i.setup) begin
      res_q <= '0;
    end else if (cmd_i.rd_capture) begin
      res_q <= rd_ok ? rdata : '0;
    end

    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      clear_q   <= 1'b1;
    end else begin
      wr_pend_q <= cmd_i.step;
      if (cmd_i.setup_clr) begin
        clear_q <= 1'b1;
      end else if (cmd_i.setup) begin
        clear_q <= (op_q == OP_CLEAR);
      end
    end
  end

  assign read_data_o = out_data_q;

endmodule

// ----- sv/page_framebuffer_rect_fill_core.sv -----
// Top level of the page-mode monochrome framebuffer with rectangle fill.
// The framebuffer holds PAGES pages of COLUMNS bytes; bit b of the byte at
// (page p, column c) is pixel row 8*p+b. Each transfer on the input carries one
// operation and yields exactly one transfer on the output: clear (every byte
// zeroed), fill (rows y_start..y_stop-1 of columns x_start..x_stop set or
// cleared, clipped to the screen, nothing drawn for empty or reversed ranges)
// and read (one stored byte; zero when off screen). read_data is zero for
// everything but a read, and an unused opcode only returns zero. One item is
// worked at a time, and the framebuffer RAM with its single read and single
// write port sets the pace: a clear or fill walks its bytes one per cycle as a
// pipelined read-modify-write, touching COLUMNS*PAGES bytes for a clear and
// clipped columns times covered pages for a fill. The output register lets
// the next item be accepted while a result still waits to be taken. After
// reset the block runs a whole-screen clearing pass with in_stall_o high.
module page_framebuffer_rect_fill_core
  import pfrf_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    op_i,
  input  logic [6:0]    x_start_i,
  input  logic [6:0]    x_stop_i,
  input  logic [5:0]    y_start_i,
  input  logic [6:0]    y_stop_i,
  input  logic          fill_white_i,
  input  logic [2:0]    read_page_i,
  input  logic [6:0]    read_column_i,
  // output channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [DW-1:0] read_data_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer: accepts a transfer only when idle, steps the datapath through
  // setup, byte walk or read, then hands the result to the output register.
  pfrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: holds the item, walks pages/columns, owns the framebuffer RAM
  // and the output data register.
  pfrf_dpath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .x_start_i     (x_start_i),
    .x_stop_i      (x_stop_i),
    .y_start_i     (y_start_i),
    .y_stop_i      (y_stop_i),
    .fill_white_i  (fill_white_i),
    .read_page_i   (read_page_i),
    .read_column_i (read_column_i),
    .read_data_o   (read_data_o)
  );

endmodule

// ----- sv/pfrf_checker.sv -----
// Port-level checker for the framebuffer fill block, bound to the top level.
module pfrf_checker
  import pfrf_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic [1:0]    op_i,
  input logic [6:0]    x_start_i,
  input logic [6:0]    x_stop_i,
  input logic [5:0]    y_start_i,
  input logic [6:0]    y_stop_i,
  input logic          fill_white_i,
  input logic [2:0]    read_page_i,
  input logic [6:0]    read_column_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic [DW-1:0] read_data_o
);

  // a stalled input transfer stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({op_i, x_start_i, x_stop_i, y_start_i, y_stop_i, fill_white_i,
               read_page_i, read_column_i}))
    else $error("input payload changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_data_o))
    else $error("result data changed while stalled");

  // one item at a time: an accepted transfer blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // a new result only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

endmodule

bind page_framebuffer_rect_fill_core pfrf_checker u_pfrf_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for the page-mode framebuffer rectangle fill core.
module tb_top;
  import pfrf_pkg::*;

  // Unused opcode: the block must leave the store alone and return zero.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_CMDS = 555;
  // Result count at which the receiver holds off for a long stretch.
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;

  // One command as offered on the input channel. 'known' marks rows whose
  // result is typed straight into the table instead of coming from our model.
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] x_start;
    logic [6:0] x_stop;
    logic [5:0] y_start;
    logic [6:0] y_stop;
    logic       fill_white;
    logic [2:0] read_page;
    logic [6:0] read_column;
    logic       known;
    logic [7:0] known_data;
  } pixel_cmd_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] op_i = OP_CLEAR;
  logic [6:0] x_start_i = '0;
  logic [6:0] x_stop_i = '0;
  logic [5:0] y_start_i = '0;
  logic [6:0] y_stop_i = '0;
  logic       fill_white_i = 1'b0;
  logic [2:0] read_page_i = '0;
  logic [6:0] read_column_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [DW-1:0] read_data_o;

  // Our own copy of the framebuffer: [page][column], bit b = row 8*page+b.
  logic [7:0] shadow_fb [PAGES_DEF][COLUMNS_DEF];
  // Bytes the block owes us, oldest first (exactly one per accepted command).
  logic [7:0] owed_bytes_q [$];
  int         errors = 0;
  // Where the last fill landed, so reads tend to hit painted pixels.
  int         last_fill_col = 0;
  int         last_fill_row = 0;

  page_framebuffer_rect_fill_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .x_start_i    (x_start_i),
    .x_stop_i     (x_stop_i),
    .y_start_i    (y_start_i),
    .y_stop_i     (y_stop_i),
    .fill_white_i (fill_white_i),
    .read_page_i  (read_page_i),
    .read_column_i(read_column_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop. Slowest legal run (every command a full-screen pass with
  // maximal gaps and stalls, plus the post-reset clear) is ~6.1M time units.
  initial begin
    #30_000_000;
    $display("FAIL page_framebuffer_rect_fill_core");
    $finish;
  end

  // Bits of page 'pg' that lie in rows [ys, ye).
  function automatic logic [7:0] row_bits(input int pg, input int ys, input int ye);
    int first;
    int past;
    logic [7:0] bits;
    first = ys - pg * 8;
    past  = ye - pg * 8;
    bits  = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= first && b < past) bits[b] = 1'b1;
    end
    return bits;
  endfunction

  // Apply one command to the shadow framebuffer; return the byte it yields.
  function automatic logic [7:0] apply_cmd(input pixel_cmd_t c);
    logic [7:0] bits;
    int         last_col;
    apply_cmd = '0;
    case (c.op)
      OP_CLEAR: begin
        foreach (shadow_fb[p, col]) shadow_fb[p][col] = '0;
      end
      OP_FILL: begin
        // Reversed columns or empty row span draw nothing.
        if (c.x_start <= c.x_stop && c.y_stop > {1'b0, c.y_start}) begin
          last_col = (c.x_stop >= COLUMNS_DEF) ? COLUMNS_DEF - 1 : int'(c.x_stop);
          for (int p = 0; p < PAGES_DEF; p++) begin
            bits = row_bits(p, c.y_start, c.y_stop);
            for (int col = c.x_start; col <= last_col; col++) begin
              if (c.fill_white) shadow_fb[p][col] = shadow_fb[p][col] | bits;
              else              shadow_fb[p][col] = shadow_fb[p][col] & ~bits;
            end
          end
        end
      end
      OP_READ: begin
        if (c.read_page < PAGES_DEF && c.read_column < COLUMNS_DEF)
          apply_cmd = shadow_fb[c.read_page][c.read_column];
      end
      default: ;
    endcase
  endfunction

  function automatic pixel_cmd_t mk(input logic [1:0] op, input int xs, input int xe,
                                    input int ys, input int ye, input logic w,
                                    input int rp, input int rc,
                                    input logic known, input logic [7:0] data);
    pixel_cmd_t c;
    c.op = op;
    c.x_start = xs[6:0];
    c.x_stop = xe[6:0];
    c.y_start = ys[5:0];
    c.y_stop = ye[6:0];
    c.fill_white = w;
    c.read_page = rp[2:0];
    c.read_column = rc[6:0];
    c.known = known;
    c.known_data = data;
    return c;
  endfunction

  // Idle count for one transfer; every fourth block of 50 runs back to back.
  function automatic int pick_wait(input int idx);
    if ((idx / 50) % 4 == 2) return 0;
    return $urandom_range(0, 7);
  endfunction

  // Random command. Mostly small fills and reads so the run stays short;
  // a few full-size fills, clears, malformed fills and unused opcodes.
  function automatic pixel_cmd_t draw_cmd();
    pixel_cmd_t c;
    int         pick;
    int         xs;
    int         xe;
    int         ys;
    int         ye;
    c = mk(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127),
           $urandom_range(0, 63), $urandom_range(0, 127), 1'($urandom_range(0, 1)),
           $urandom_range(0, 7), $urandom_range(0, 127), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 44) begin
      c.op = OP_READ;
      if ($urandom_range(0, 1)) begin
        c.read_column = 7'(last_fill_col + $urandom_range(0, 3));
        c.read_page   = 3'(last_fill_row / 8);
      end
    end else if (pick < 94) begin
      c.op = OP_FILL;
      if (pick >= 88) begin
        // near full screen, rows may run past the bottom edge
        xs = $urandom_range(0, 15);
        xe = $urandom_range(100, 127);
        ys = $urandom_range(0, 15);
        ye = $urandom_range(40, 127);
      end else if (pick >= 82) begin
        // malformed: reversed columns or empty/reversed rows
        xs = $urandom_range(1, 127);
        ys = $urandom_range(0, 63);
        if ($urandom_range(0, 1)) begin
          xe = $urandom_range(0, xs - 1);
          ye = $urandom_range(0, 127);
        end else begin
          xe = $urandom_range(xs, 127);
          ye = $urandom_range(0, ys);
        end
      end else begin
        xs = $urandom_range(0, 127);
        xe = xs + $urandom_range(0, 15);
        if (xe > 127) xe = 127;
        ys = $urandom_range(0, 63);
        ye = ys + $urandom_range(1, 12);
      end
      c.x_start = xs[6:0];
      c.x_stop  = xe[6:0];
      c.y_start = ys[5:0];
      c.y_stop  = ye[6:0];
      last_fill_col = xs;
      last_fill_row = ys;
    end else if (pick < 97) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // Offer one command and hold it until the transfer; the model is updated
  // at the accepting edge. Valid is only dropped when a gap is taken, so it
  // never gets two assignments in one step.
  task automatic offer(input pixel_cmd_t c, input int idx);
    int         gap;
    logic [7:0] modeled;
    gap = pick_wait(idx);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= c.op;
    x_start_i     <= c.x_start;
    x_stop_i      <= c.x_stop;
    y_start_i     <= c.y_start;
    y_stop_i      <= c.y_stop;
    fill_white_i  <= c.fill_white;
    read_page_i   <= c.read_page;
    read_column_i <= c.read_column;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    modeled = apply_cmd(c);
    owed_bytes_q.push_back(c.known ? c.known_data : modeled);
  endtask

  // Output side: random stall per transfer, one long hold-off early in the
  // random part so the output register fills and the input backs up.
  initial begin : result_drain
    int hold_left;
    int wait_left;
    int taken;
    logic [7:0] owed;
    hold_left = 0;
    taken     = 0;
    wait_left = pick_wait(0);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (owed_bytes_q.size() == 0) begin
          $error("read_data: unexpected transfer, got %0h", read_data_o);
          errors++;
        end else begin
          owed = owed_bytes_q.pop_front();
          if (read_data_o !== owed) begin
            $error("read_data mismatch: expected %0h, actual %0h", owed, read_data_o);
            errors++;
          end
        end
        taken++;
        wait_left = pick_wait(taken);
        if (taken == HOLD_AT) hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_stall_i <= (hold_left > 0) || (wait_left > 0);
    end
  end

  initial begin : stimulus
    pixel_cmd_t directed_q [$];
    int         idx;
    foreach (shadow_fb[p, col]) shadow_fb[p][col] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // op, xs, xe, ys, ye, white, page, col, typed?, typed byte
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 0,   0, 1, 8'h00)); // fresh store
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 7, 127, 1, 8'h00));
    directed_q.push_back(mk(OP_FILL,    0, 127,  0, 64, 1, 7, 127, 1, 8'h00)); // whole screen
    directed_q.push_back(mk(OP_READ,  127,   0, 63,  0, 1, 0,   0, 1, 8'hFF));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 7, 127, 1, 8'hFF));
    // partial first and last pages, black
    directed_q.push_back(mk(OP_FILL,    0, 127,  3, 61, 0, 0,   0, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 0,   5, 1, 8'h07));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 7, 127, 1, 8'hE0));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 3,  64, 1, 8'h00));
    // reversed columns draw nothing
    directed_q.push_back(mk(OP_FILL,   10,   9,  0, 64, 1, 0,   0, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 3,  10, 1, 8'h00));
    // empty and reversed row spans draw nothing
    directed_q.push_back(mk(OP_FILL,    0, 127, 20, 20, 1, 0,   0, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 2,   0, 1, 8'h00));
    directed_q.push_back(mk(OP_FILL,    0, 127, 40, 30, 1, 0,   0, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 4,   0, 1, 8'h00));
    // rows run off the bottom edge, y_stop all ones
    directed_q.push_back(mk(OP_FILL,  100, 127, 60, 127, 1, 0,  0, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 7, 100, 0, 8'h00));
    // single pixel
    directed_q.push_back(mk(OP_FILL,   63,  63, 33, 34, 1, 0,   0, 0, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 4,  63, 0, 8'h00));
    // unused opcode with every field at its top value
    directed_q.push_back(mk(OP_UNUSED, 127, 127, 63, 127, 1, 7, 127, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 7, 127, 0, 8'h00));
    // one column cleared top to bottom
    directed_q.push_back(mk(OP_FILL,  127, 127,  0, 64, 0, 0,   0, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 7, 127, 0, 8'h00));
    // clear with junk in every other field
    directed_q.push_back(mk(OP_CLEAR, 127, 127, 63, 127, 1, 7, 127, 1, 8'h00));
    directed_q.push_back(mk(OP_READ,    0,   0,  0,  0, 0, 4,  63, 1, 8'h00));

    idx = 0;
    foreach (directed_q[i]) begin
      offer(directed_q[i], idx);
      idx++;
    end
    repeat (RANDOM_CMDS) begin
      offer(draw_cmd(), idx);
      idx++;
    end
    in_valid_i <= 1'b0;

    // Let the last results drain, then a few idle cycles to catch strays.
    while (owed_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS page_framebuffer_rect_fill_core");
    end else begin
      $display("FAIL page_framebuffer_rect_fill_core");
    end
    $finish;
  end

endmodule
